@@ rtl/core/lfd_pkg.sv @@
`default_nettype none

package lfd_pkg;

    // number of drop IR sensors carried by one tick
    localparam int NUM_IR = 6;
    localparam int IR_W = 12;
    localparam int ACCEL_W = 18;
    localparam int TIME_W = 32;
    localparam int LIMIT_W = 16;
    localparam int DROP_CNT_W = $clog2(NUM_IR + 1);

    // default leaky counter width
    localparam int COUNTER_BITS_DEF = 16;

    // charger contacts flag inside the dock status byte
    localparam int CHARGER_BIT = 4;

    // register reset values
    localparam logic [11:0] IR_THRESHOLD_RST = 12'd900;
    localparam logic [2:0] IR_COUNT_MIN_RST = 3'd4;
    localparam logic signed [17:0] ACCEL_LOW_RST = 18'sd9200;
    localparam logic signed [17:0] ACCEL_HIGH_RST = 18'sd10500;
    localparam logic [15:0] COUNT_LIMIT_RST = 16'd10;
    localparam logic [15:0] HOLD_MS_RST = 16'd2000;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_IR_THRESHOLD = 3'd0,
        REG_IR_COUNT_MIN = 3'd1,
        REG_ACCEL_LOW    = 3'd2,
        REG_ACCEL_HIGH   = 3'd3,
        REG_COUNT_LIMIT  = 3'd4,
        REG_HOLD_MS      = 3'd5
    } reg_index_t;

    // settings used by the state update stage
    typedef struct packed {
        logic [2:0]  ir_count_min;
        logic [15:0] count_limit;
        logic [15:0] hold_ms;
    } state_cfg_t;

    // pre-processed tick from the lane stage
    typedef struct packed {
        logic [NUM_IR-1:0] drop;
        logic              charger;
        logic              accel_out;
        logic [31:0]       now;
    } tick_t;

    // one result beat
    typedef struct packed {
        logic        lift_error;
        logic        ir_lift;
        logic        imu_lift;
        logic [15:0] leaky_count;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/core/lfd_lane.sv @@
`default_nettype none

module lfd_lane
    import lfd_pkg::*;
(
    input  wire logic [IR_W-1:0] ir,
    input  wire logic [IR_W-1:0] threshold,
    output logic                 drop
);

    // a sensor sees a drop when its reading is below threshold
    assign drop = (ir < threshold);

endmodule

`default_nettype wire

@@ rtl/core/lfd_state.sv @@
`default_nettype none

module lfd_state
    import lfd_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       fire,
    input  wire tick_t      tick,
    input  wire state_cfg_t cfg,
    input  wire logic       out_ready,
    output logic            out_valid,
    output result_t         result
);

    localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

    logic [COUNTER_BITS-1:0] counter_reg, counter_next;
    logic                    cand_reg, cand_next;
    logic [TIME_W-1:0]       start_reg, start_next;
    logic                    err_reg, err_next;
    logic                    out_valid_reg, out_valid_next;
    result_t                 result_reg, result_next;

    logic [DROP_CNT_W-1:0]   drops;
    logic                    clear;
    logic                    ir_lift;
    logic                    imu_lift;
    logic [COUNTER_BITS-1:0] cnt_base;
    logic [31:0]             cnt_ext;
    logic                    meet;
    logic [TIME_W-1:0]       elapsed;
    logic                    hold_done;

    // merge the lane results into a drop count
    always_comb
    begin
        drops = '0;
        for (int i = 0; i < NUM_IR; i++)
        begin
            drops = drops + DROP_CNT_W'(tick.drop[i]);
        end
    end

    // lift flags
    assign clear    = (drops == '0) || tick.charger;
    assign ir_lift  = !clear && (drops >= DROP_CNT_W'(cfg.ir_count_min));
    assign imu_lift = ir_lift && tick.accel_out;

    // elapsed time against the stored start, the new start gives zero
    assign elapsed = tick.now - start_reg;

    // state update
    always_comb
    begin
        cnt_base = clear ? '0 : counter_reg;
        if (imu_lift)
        begin
            counter_next = (cnt_base == CNT_MAX) ? cnt_base : cnt_base + 1'b1;
        end
        else
        begin
            counter_next = (cnt_base == '0) ? cnt_base : cnt_base - 1'b1;
        end
        cnt_ext = 32'(counter_next);
        meet    = (cnt_ext >= 32'(cfg.count_limit));

        start_next = start_reg;
        hold_done  = (elapsed >= TIME_W'(cfg.hold_ms));
        if (meet && !cand_reg)
        begin
            start_next = tick.now;
            hold_done  = (cfg.hold_ms == '0);
        end

        err_next  = clear ? 1'b0 : err_reg;
        cand_next = cand_reg || meet;
        if (cand_next)
        begin
            if (!ir_lift)
            begin
                cand_next = 1'b0;
            end
            else if (hold_done)
            begin
                err_next = 1'b1;
            end
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        result_next    = result_reg;
        if (fire)
        begin
            out_valid_next          = 1'b1;
            result_next.lift_error  = err_next;
            result_next.ir_lift     = ir_lift;
            result_next.imu_lift    = imu_lift;
            result_next.leaky_count = cnt_ext[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg   <= '0;
            cand_reg      <= 1'b0;
            start_reg     <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                counter_reg <= counter_next;
                cand_reg    <= cand_next;
                start_reg   <= start_next;
                err_reg     <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

`ifndef SYNTHESIS
    // imu flag on a result never stands without the ir flag
    a_imu_needs_ir: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.imu_lift |-> result_reg.ir_lift)
        else $error("imu lift without ir lift");

    // a tick without ir lift leaves no candidate
    a_cand_drop: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !ir_lift |=> !cand_reg)
        else $error("candidate survived a tick without ir lift");

    // a clearing tick empties the counter and the error
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        fire && clear |=> counter_reg == '0 && !err_reg)
        else $error("clearing tick left state behind");

    // a new result is only taken when the output register is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !fire)
        else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

@@ rtl/core/lift_fault_detector_top.sv @@
`default_nettype none

// Lift fault detector. Accepts one monitoring tick per clock cycle while the
// result output is not stalled. A lane stage compares the six drop IR
// readings and the acceleration window in parallel and registers them; the
// second stage counts the drops, updates the leaky counter, candidate and
// error latch and holds the result in an output register, so a new tick is
// taken while a result waits. Ticks with sensors_fresh or all_updated low
// are accepted and give no result beat. Configuration is to be written by
// the user through the cfg port (always ready) while no tick is in flight;
// the block itself does not enforce this.
module lift_fault_detector_top
    import lfd_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic                      sensors_fresh,
    input  wire logic                      all_updated,
    input  wire logic [IR_W-1:0]           ir_front,
    input  wire logic [IR_W-1:0]           ir_front_left,
    input  wire logic [IR_W-1:0]           ir_front_right,
    input  wire logic [IR_W-1:0]           ir_back,
    input  wire logic [IR_W-1:0]           ir_back_left,
    input  wire logic [IR_W-1:0]           ir_back_right,
    input  wire logic [7:0]                dock_status,
    input  wire logic signed [ACCEL_W-1:0] accel_z,
    input  wire logic [TIME_W-1:0]         now_ms,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic                           lift_error,
    output logic                           ir_lift,
    output logic                           imu_lift,
    output logic [15:0]                    leaky_count,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [2:0]                cfg_index,
    input  wire logic [31:0]               cfg_data
);

    logic [IR_W-1:0]           ir_threshold_reg;
    logic [2:0]                ir_count_min_reg;
    logic signed [ACCEL_W-1:0] accel_low_reg;
    logic signed [ACCEL_W-1:0] accel_high_reg;
    logic [LIMIT_W-1:0]        count_limit_reg;
    logic [LIMIT_W-1:0]        hold_ms_reg;

    logic              s1_valid_reg, s1_valid_next;
    tick_t             s1_tick_reg, s1_tick_next;
    logic [NUM_IR-1:0] drop;
    logic [IR_W-1:0]   ir_vec [NUM_IR];
    logic              stall;
    logic              fire;
    logic              in_beat;
    state_cfg_t        scfg;
    result_t           result;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ir_threshold_reg <= IR_THRESHOLD_RST;
            ir_count_min_reg <= IR_COUNT_MIN_RST;
            accel_low_reg    <= ACCEL_LOW_RST;
            accel_high_reg   <= ACCEL_HIGH_RST;
            count_limit_reg  <= COUNT_LIMIT_RST;
            hold_ms_reg      <= HOLD_MS_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_IR_THRESHOLD: ir_threshold_reg <= cfg_data[IR_W-1:0];
                REG_IR_COUNT_MIN: ir_count_min_reg <= cfg_data[2:0];
                REG_ACCEL_LOW:    accel_low_reg    <= signed'(cfg_data[ACCEL_W-1:0]);
                REG_ACCEL_HIGH:   accel_high_reg   <= signed'(cfg_data[ACCEL_W-1:0]);
                REG_COUNT_LIMIT:  count_limit_reg  <= cfg_data[LIMIT_W-1:0];
                REG_HOLD_MS:      hold_ms_reg      <= cfg_data[LIMIT_W-1:0];
                default:          ;
            endcase
        end
    end

    // one compare lane per drop sensor
    assign ir_vec[0] = ir_front;
    assign ir_vec[1] = ir_front_left;
    assign ir_vec[2] = ir_front_right;
    assign ir_vec[3] = ir_back;
    assign ir_vec[4] = ir_back_left;
    assign ir_vec[5] = ir_back_right;

    for (genvar g = 0; g < NUM_IR; g++)
    begin : g_lane
        lfd_lane u_lane (
            .ir        (ir_vec[g]),
            .threshold (ir_threshold_reg),
            .drop      (drop[g])
        );
    end

    // pipeline handshake
    assign stall    = out_valid && !out_ready;
    assign in_ready = !s1_valid_reg || !stall;
    assign in_beat  = in_valid && in_ready;
    assign fire     = s1_valid_reg && !stall;

    // lane stage register, skipped ticks leave a bubble
    always_comb
    begin
        s1_valid_next = s1_valid_reg && !fire;
        s1_tick_next  = s1_tick_reg;
        if (in_beat)
        begin
            s1_valid_next          = sensors_fresh && all_updated;
            s1_tick_next.drop      = drop;
            s1_tick_next.charger   = dock_status[CHARGER_BIT];
            s1_tick_next.accel_out = (accel_z <= accel_low_reg) ||
                                     (accel_z >= accel_high_reg);
            s1_tick_next.now       = now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tick_reg <= s1_tick_next;
    end

    // merge and state stage
    assign scfg.ir_count_min = ir_count_min_reg;
    assign scfg.count_limit  = count_limit_reg;
    assign scfg.hold_ms      = hold_ms_reg;

    lfd_state #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .tick      (s1_tick_reg),
        .cfg       (scfg),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .result    (result)
    );

    assign lift_error  = result.lift_error;
    assign ir_lift     = result.ir_lift;
    assign imu_lift    = result.imu_lift;
    assign leaky_count = result.leaky_count;

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
module tb_top;
    import lfd_pkg::*;

    localparam int IDLE_PCT = 16;
    localparam int SETTLE = 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int STALL_AT = 400;
    localparam int STALL_LEN = 300;
    localparam int CALM_FROM = 600;
    localparam int CALM_TO = 800;
    localparam int ACCEL_MIN = -78480;
    localparam int ACCEL_MAX = 78480;
    localparam logic [COUNTER_BITS_DEF-1:0] COUNTER_FULL = '1;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_CFG,
        OP_DRAIN
    } op_kind_t;

    typedef enum int {
        ACC_OUT,
        ACC_IN,
        ACC_ANY
    } accel_kind_t;

    typedef struct packed {
        logic                        fresh;
        logic                        updated;
        logic [NUM_IR-1:0][IR_W-1:0] ir;
        logic [7:0]                  dock;
        logic [ACCEL_W-1:0]          accel;
        logic [TIME_W-1:0]           now;
    } tick_in_t;

    typedef struct packed {
        op_kind_t    kind;
        tick_in_t    tick;
        reg_index_t  idx;
        logic [31:0] data;
    } op_t;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // block inputs, known from time zero
    logic                      in_valid = 1'b0;
    logic                      sensors_fresh = 1'b0;
    logic                      all_updated = 1'b0;
    logic [IR_W-1:0]           ir_front = '0;
    logic [IR_W-1:0]           ir_front_left = '0;
    logic [IR_W-1:0]           ir_front_right = '0;
    logic [IR_W-1:0]           ir_back = '0;
    logic [IR_W-1:0]           ir_back_left = '0;
    logic [IR_W-1:0]           ir_back_right = '0;
    logic [7:0]                dock_status = '0;
    logic signed [ACCEL_W-1:0] accel_z = '0;
    logic [TIME_W-1:0]         now_ms = '0;
    logic                      out_ready = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic [2:0]                cfg_index = '0;
    logic [31:0]               cfg_data = '0;

    // block outputs
    logic        in_ready;
    logic        out_valid;
    logic        cfg_ready;
    logic        lift_error;
    logic        ir_lift;
    logic        imu_lift;
    logic [15:0] leaky_count;

    // plan of beats and expected results
    op_t     tick_plan[$];
    result_t pending_results[$];
    tick_in_t cur_tick;
    int ticks_sent = 0;
    int quiet_cycles = 0;
    int mismatches = 0;
    int cycle_count = 0;
    int stall_left = 0;
    bit stall_done = 1'b0;

    // detector state and settings as predicted
    logic [IR_W-1:0]             lm_threshold = IR_THRESHOLD_RST;
    logic [2:0]                  lm_count_min = IR_COUNT_MIN_RST;
    logic signed [ACCEL_W-1:0]   lm_accel_low = ACCEL_LOW_RST;
    logic signed [ACCEL_W-1:0]   lm_accel_high = ACCEL_HIGH_RST;
    logic [15:0]                 lm_count_limit = COUNT_LIMIT_RST;
    logic [15:0]                 lm_hold = HOLD_MS_RST;
    logic [COUNTER_BITS_DEF-1:0] lm_counter = '0;
    logic                        lm_cand_active = 1'b0;
    logic [TIME_W-1:0]           lm_cand_start = '0;
    logic                        lm_error = 1'b0;

    // settings the stimulus generator shapes its ticks for
    int gen_thr;
    int gen_alo;
    int gen_ahi;
    int gen_step_max;
    int gen_skip_pct;
    logic [TIME_W-1:0] gen_now;

    lift_fault_detector_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sensors_fresh  (sensors_fresh),
        .all_updated    (all_updated),
        .ir_front       (ir_front),
        .ir_front_left  (ir_front_left),
        .ir_front_right (ir_front_right),
        .ir_back        (ir_back),
        .ir_back_left   (ir_back_left),
        .ir_back_right  (ir_back_right),
        .dock_status    (dock_status),
        .accel_z        (accel_z),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .lift_error     (lift_error),
        .ir_lift        (ir_lift),
        .imu_lift       (imu_lift),
        .leaky_count    (leaky_count),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // one detector update for an accepted tick
    function automatic void predict_lift_tick(input tick_in_t t);
        int drops;
        int k;
        logic signed [ACCEL_W-1:0] az;
        logic ir_flag;
        logic imu_flag;
        logic [TIME_W-1:0] elapsed;
        result_t r;
        if (!(t.fresh && t.updated))
            return;
        drops = 0;
        for (k = 0; k < NUM_IR; k++)
        begin
            if (t.ir[k] < lm_threshold)
                drops++;
        end
        az = t.accel;
        // nothing dropped or on the charger clears the counter and the error
        if (drops == 0 || t.dock[CHARGER_BIT])
        begin
            lm_counter = '0;
            lm_error = 1'b0;
            ir_flag = 1'b0;
        end
        else
        begin
            ir_flag = (drops >= lm_count_min);
        end
        imu_flag = ir_flag && (az <= lm_accel_low || az >= lm_accel_high);
        // saturating leaky counter
        if (ir_flag && imu_flag)
        begin
            if (lm_counter != COUNTER_FULL)
                lm_counter++;
        end
        else if (lm_counter != '0)
        begin
            lm_counter--;
        end
        // candidate start, drop and error latch
        if (lm_counter >= lm_count_limit)
        begin
            if (!lm_cand_active)
                lm_cand_start = t.now;
            lm_cand_active = 1'b1;
        end
        if (lm_cand_active)
        begin
            if (!ir_flag)
            begin
                lm_cand_active = 1'b0;
            end
            else
            begin
                elapsed = t.now - lm_cand_start;
                if (elapsed >= {16'd0, lm_hold})
                    lm_error = 1'b1;
            end
        end
        r.lift_error = lm_error;
        r.ir_lift = ir_flag;
        r.imu_lift = imu_flag;
        r.leaky_count = lm_counter[15:0];
        pending_results.push_back(r);
    endfunction

    function automatic void apply_lift_reg(input reg_index_t idx, input logic [31:0] d);
        case (idx)
            REG_IR_THRESHOLD: lm_threshold = d[IR_W-1:0];
            REG_IR_COUNT_MIN: lm_count_min = d[2:0];
            REG_ACCEL_LOW:    lm_accel_low = d[ACCEL_W-1:0];
            REG_ACCEL_HIGH:   lm_accel_high = d[ACCEL_W-1:0];
            REG_COUNT_LIMIT:  lm_count_limit = d[15:0];
            REG_HOLD_MS:      lm_hold = d[15:0];
            default:          ;
        endcase
    endfunction

    function automatic int rand_int(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic void push_tick(input tick_in_t t);
        op_t op;
        op = '0;
        op.kind = OP_TICK;
        op.tick = t;
        tick_plan.push_back(op);
    endfunction

    function automatic void push_cfg(input reg_index_t idx, input logic [31:0] d);
        op_t op;
        op = '0;
        op.kind = OP_CFG;
        op.idx = idx;
        op.data = d;
        tick_plan.push_back(op);
    endfunction

    function automatic void push_drain();
        op_t op;
        op = '0;
        op.kind = OP_DRAIN;
        tick_plan.push_back(op);
    endfunction

    // fixed tick: the first n_drop sensors read lo, the rest hi
    function automatic tick_in_t dir_tick(input bit fresh, input bit upd, input int n_drop,
                                          input logic [IR_W-1:0] lo, input logic [IR_W-1:0] hi,
                                          input logic [7:0] dock, input int accel,
                                          input logic [TIME_W-1:0] now);
        tick_in_t t;
        int k;
        t.fresh = fresh;
        t.updated = upd;
        for (k = 0; k < NUM_IR; k++)
            t.ir[k] = (k < n_drop) ? lo : hi;
        t.dock = dock;
        t.accel = ACCEL_W'(accel);
        t.now = now;
        return t;
    endfunction

    // random tick with n_drop sensors below the threshold at random places, none when the threshold is zero
    function automatic tick_in_t shape_tick(input int n_drop, input bit charger,
                                            input accel_kind_t akind);
        tick_in_t t;
        int need;
        int left;
        int k;
        int a;
        t.fresh = ($urandom_range(99) >= gen_skip_pct);
        t.updated = ($urandom_range(99) >= gen_skip_pct);
        need = n_drop;
        left = NUM_IR;
        for (k = 0; k < NUM_IR; k++)
        begin
            if (gen_thr > 0 && int'($urandom_range(left - 1)) < need)
            begin
                t.ir[k] = IR_W'($urandom_range(gen_thr - 1));
                need--;
            end
            else
            begin
                t.ir[k] = IR_W'($urandom_range(4095, gen_thr));
            end
            left--;
        end
        t.dock = 8'($urandom_range(255));
        t.dock[CHARGER_BIT] = charger;
        case (akind)
            ACC_OUT:
            begin
                if ($urandom_range(1) == 0)
                    a = rand_int(ACCEL_MIN, gen_alo);
                else
                    a = rand_int(gen_ahi, ACCEL_MAX);
            end
            ACC_IN:
            begin
                if (gen_alo + 1 <= gen_ahi - 1)
                    a = rand_int(gen_alo + 1, gen_ahi - 1);
                else
                    a = rand_int(ACCEL_MIN, ACCEL_MAX);
            end
            default: a = rand_int(ACCEL_MIN, ACCEL_MAX);
        endcase
        t.accel = ACCEL_W'(a);
        gen_now = gen_now + TIME_W'($urandom_range(gen_step_max));
        t.now = gen_now;
        return t;
    endfunction

    // write every register, then bursts of lift ticks mixed with other traffic
    task automatic run_phase(input int count, input int thr, input int cmin, input int alo,
                             input int ahi, input int limit, input int hold,
                             input int step_max);
        int made;
        int len;
        int pick;
        int k;
        int lift_min;
        tick_in_t t;
        push_cfg(REG_IR_THRESHOLD, 32'(thr));
        push_cfg(REG_IR_COUNT_MIN, 32'(cmin));
        push_cfg(REG_ACCEL_LOW, 32'(alo));
        push_cfg(REG_ACCEL_HIGH, 32'(ahi));
        push_cfg(REG_COUNT_LIMIT, 32'(limit));
        push_cfg(REG_HOLD_MS, 32'(hold));
        gen_thr = thr;
        gen_alo = alo;
        gen_ahi = ahi;
        gen_step_max = step_max;
        gen_skip_pct = 4;
        gen_now = $urandom;
        lift_min = (cmin == 0) ? 1 : ((cmin > NUM_IR) ? NUM_IR : cmin);
        made = 0;
        while (made < count)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
                len = $urandom_range(40, 1);
            else if (pick < 70)
                len = $urandom_range(3, 1);
            else if (pick < 80)
                len = $urandom_range(2, 1);
            else if (pick < 88)
                len = 1;
            else
                len = $urandom_range(3, 1);
            for (k = 0; k < len; k++)
            begin
                if (pick < 55)
                begin
                    // lift burst, now and then a tick inside the window
                    t = shape_tick($urandom_range(NUM_IR, lift_min), 1'b0,
                                   ($urandom_range(9) == 0) ? ACC_IN : ACC_OUT);
                end
                else if (pick < 70)
                begin
                    // too few drops for the IR flag
                    t = shape_tick($urandom_range(lift_min - 1), 1'b0, ACC_ANY);
                end
                else if (pick < 80)
                begin
                    t = shape_tick(0, 1'b0, ACC_ANY);
                end
                else if (pick < 88)
                begin
                    t = shape_tick($urandom_range(NUM_IR), 1'b1, ACC_OUT);
                end
                else
                begin
                    // unshaped noise with a time jump
                    t = shape_tick(0, 1'b0, ACC_ANY);
                    t.fresh = ($urandom_range(9) != 0);
                    t.updated = ($urandom_range(9) != 0);
                    t.ir = {NUM_IR * IR_W{1'b0}};
                    for (int s = 0; s < NUM_IR; s++)
                        t.ir[s] = IR_W'($urandom_range(4095));
                    t.now = $urandom;
                    gen_now = t.now;
                end
                push_tick(t);
                made++;
            end
        end
        push_drain();
    endtask

    // driver: ticks and register writes from the plan
    always @(posedge clk or negedge rst_n)
    begin
        op_t op;
        logic next_in_valid;
        logic next_cfg_valid;
        logic calm;
        logic settled;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cfg_valid <= 1'b0;
            quiet_cycles = 0;
        end
        else
        begin
            calm = (ticks_sent >= CALM_FROM && ticks_sent < CALM_TO);
            next_in_valid = in_valid && !in_ready;
            next_cfg_valid = cfg_valid && !cfg_ready;
            if (quiet_cycles < SETTLE)
                quiet_cycles++;
            if (in_valid && in_ready)
            begin
                predict_lift_tick(cur_tick);
                ticks_sent <= ticks_sent + 1;
                quiet_cycles = 0;
            end
            if (cfg_valid && cfg_ready)
                apply_lift_reg(reg_index_t'(cfg_index), cfg_data);
            settled = (pending_results.size() == 0 && quiet_cycles >= SETTLE);
            if (!next_in_valid && !next_cfg_valid && tick_plan.size() != 0)
            begin
                case (tick_plan[0].kind)
                    OP_TICK:
                    begin
                        if (calm || $urandom_range(99) >= IDLE_PCT)
                        begin
                            op = tick_plan.pop_front();
                            cur_tick = op.tick;
                            sensors_fresh <= op.tick.fresh;
                            all_updated <= op.tick.updated;
                            ir_front <= op.tick.ir[0];
                            ir_front_left <= op.tick.ir[1];
                            ir_front_right <= op.tick.ir[2];
                            ir_back <= op.tick.ir[3];
                            ir_back_left <= op.tick.ir[4];
                            ir_back_right <= op.tick.ir[5];
                            dock_status <= op.tick.dock;
                            accel_z <= op.tick.accel;
                            now_ms <= op.tick.now;
                            next_in_valid = 1'b1;
                        end
                    end
                    OP_CFG:
                    begin
                        if (settled)
                        begin
                            op = tick_plan.pop_front();
                            cfg_index <= op.idx;
                            cfg_data <= op.data;
                            next_cfg_valid = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (settled)
                            void'(tick_plan.pop_front());
                    end
                endcase
            end
            in_valid <= next_in_valid;
            cfg_valid <= next_cfg_valid;
        end
    end

    // receiver: random idling, one long hold-off while ticks keep coming
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
            stall_done = 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (!stall_done && ticks_sent >= STALL_AT)
        begin
            stall_left = STALL_LEN;
            stall_done = 1'b1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= (ticks_sent >= CALM_FROM && ticks_sent < CALM_TO) ||
                         ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // monitor: each result beat against the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with no expected result");
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (lift_error !== want.lift_error)
                begin
                    $error("lift_error expected %0d got %0d", want.lift_error, lift_error);
                    mismatches++;
                end
                if (ir_lift !== want.ir_lift)
                begin
                    $error("ir_lift expected %0d got %0d", want.ir_lift, ir_lift);
                    mismatches++;
                end
                if (imu_lift !== want.imu_lift)
                begin
                    $error("imu_lift expected %0d got %0d", want.imu_lift, imu_lift);
                    mismatches++;
                end
                if (leaky_count !== want.leaky_count)
                begin
                    $error("leaky_count expected %0d got %0d", want.leaky_count, leaky_count);
                    mismatches++;
                end
            end
        end
    end

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // stimulus plan and end of run
    initial
    begin
        int k;
        int thr;
        int alo;
        gen_thr = IR_THRESHOLD_RST;
        gen_alo = ACCEL_LOW_RST;
        gen_ahi = ACCEL_HIGH_RST;
        gen_step_max = 1;
        gen_skip_pct = 0;
        gen_now = '0;

        // directed ticks at reset settings
        push_tick(dir_tick(1'b0, 1'b1, 6, 12'd0, 12'd4095, 8'h00, ACCEL_MIN, 32'd0));
        push_tick(dir_tick(1'b1, 1'b0, 6, 12'd0, 12'd4095, 8'h00, ACCEL_MIN, 32'd0));
        push_tick(dir_tick(1'b0, 1'b0, 6, 12'd0, 12'd4095, 8'h00, ACCEL_MIN, 32'd0));
        push_tick(dir_tick(1'b1, 1'b1, 6, 12'd0, 12'd4095, 8'h00, ACCEL_MIN, 32'd0));
        push_tick(dir_tick(1'b1, 1'b1, 0, 12'd0, 12'd4095, 8'h00, ACCEL_MAX, 32'hFFFF_FFFF));
        push_tick(dir_tick(1'b1, 1'b1, 4, 12'd899, 12'd900, 8'hEF, 9200, 32'd10));
        push_tick(dir_tick(1'b1, 1'b1, 4, 12'd899, 12'd900, 8'h00, 10500, 32'd20));
        push_tick(dir_tick(1'b1, 1'b1, 4, 12'd899, 12'd900, 8'h00, 9201, 32'd30));
        push_tick(dir_tick(1'b1, 1'b1, 3, 12'd899, 12'd900, 8'h00, ACCEL_MIN, 32'd40));
        push_tick(dir_tick(1'b1, 1'b1, 6, 12'd0, 12'd4095, 8'h10, ACCEL_MIN, 32'd50));
        push_tick(dir_tick(1'b1, 1'b1, 6, 12'd0, 12'd4095, 8'hFF, ACCEL_MIN, 32'd60));
        // ticks across the clock wrap build a candidate, error latches after the hold
        for (k = 0; k < 13; k++)
            push_tick(dir_tick(1'b1, 1'b1, 6, 12'd100, 12'd3000, 8'h00, -50000,
                               32'hFFFF_E000 + 32'(k * 1000)));
        // candidate dropped, then everything cleared
        push_tick(dir_tick(1'b1, 1'b1, 2, 12'd100, 12'd3000, 8'h00, -50000, 32'h0000_2000));
        push_tick(dir_tick(1'b1, 1'b1, 0, 12'd100, 12'd3000, 8'h00, -50000, 32'h0000_2400));
        push_drain();

        // random phases, extreme settings first
        run_phase(150, 900, 4, 9200, 10500, 5, 100, 20);
        run_phase(150, 4095, 0, ACCEL_MIN, ACCEL_MAX, 1, 0, 40);
        run_phase(150, 2500, 1, 20000, -20000, 0, 50, 10);
        run_phase(60, 0, 7, 0, 1, 65535, 65535, 1000);
        for (k = 0; k < 4; k++)
        begin
            thr = $urandom_range(4095, 1);
            alo = rand_int(-20000, 12000);
            run_phase(150, thr, $urandom_range(NUM_IR, 1), alo, rand_int(alo, 40000),
                      $urandom_range(30, 1), $urandom_range(800), $urandom_range(50, 1));
        end

        // lift run against the widest count limit, then cleared
        push_cfg(REG_IR_THRESHOLD, 32'd2000);
        push_cfg(REG_IR_COUNT_MIN, 32'd1);
        push_cfg(REG_ACCEL_LOW, 32'd0);
        push_cfg(REG_ACCEL_HIGH, 32'd0);
        push_cfg(REG_COUNT_LIMIT, 32'd65535);
        push_cfg(REG_HOLD_MS, 32'd300);
        gen_thr = 2000;
        gen_alo = 0;
        gen_ahi = 0;
        gen_step_max = 2;
        gen_skip_pct = 1;
        gen_now = $urandom;
        for (k = 0; k < 20; k++)
            push_tick(shape_tick($urandom_range(NUM_IR, 1), 1'b0, ACC_ANY));
        for (k = 0; k < 4; k++)
            push_tick(shape_tick(0, 1'b0, ACC_ANY));
        push_drain();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (tick_plan.size() != 0 || in_valid || cfg_valid || pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
